[design/whole_word_match_counter_defines.svh]
// Assertion macros shared by the checker.
`ifndef WHOLE_WORD_MATCH_COUNTER_DEFINES_SVH
`define WHOLE_WORD_MATCH_COUNTER_DEFINES_SVH

// Overlapping implication, sampled on the rising edge, off during reset.
`define WWMC_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> cons) else $error(msg);

// Next-cycle implication, sampled on the rising edge, off during reset.
`define WWMC_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> cons) else $error(msg);

`endif

[design/wwmc_pkg.sv]
package wwmc_pkg;

    localparam int DEF_MAX_WORD_LEN = 10;
    localparam int DEF_COUNT_BITS   = 32;

    localparam int BYTE_W           = 8;
    localparam int OUT_W            = 32;
    localparam int ADDR_W           = 5;
    localparam int DATA_W           = 64;
    localparam int WORD_FIRST_BYTES = 8;
    localparam int WORD_BYTES       = 10;
    localparam int REST_W           = 16;
    localparam int LEN_REG_W        = 4;

    localparam logic [BYTE_W-1:0] FOLD_LO   = 8'd65;
    localparam logic [BYTE_W-1:0] FOLD_HI   = 8'd90;
    localparam logic [BYTE_W-1:0] LETTER_LO = 8'd97;
    localparam logic [BYTE_W-1:0] LETTER_HI = 8'd122;
    localparam logic [BYTE_W-1:0] CASE_GAP  = 8'd32;

    // register index = paddr[4:3]
    localparam logic [1:0] REG_WORD_FIRST = 2'd0;
    localparam logic [1:0] REG_WORD_REST  = 2'd1;
    localparam logic [1:0] REG_WORD_LEN   = 2'd2;

    typedef struct packed {
        logic shift;
        logic flush;
    } cell_ctl_t;

    function automatic logic [BYTE_W-1:0] fold(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] r;
        r = b;
        if (b >= FOLD_LO && b <= FOLD_HI)
            r = b + CASE_GAP;
        return r;
    endfunction

    function automatic logic is_letter(input logic [BYTE_W-1:0] b);
        return (b >= LETTER_LO) && (b <= LETTER_HI);
    endfunction

endpackage

[design/wwmc_cell.sv]
module wwmc_cell (
    input  logic                      clk,
    input  logic                      rst_n,
    input  wwmc_pkg::cell_ctl_t       ctl,
    input  logic [wwmc_pkg::BYTE_W-1:0] byte_in,
    input  logic                      valid_in,
    input  logic [wwmc_pkg::BYTE_W-1:0] target,
    output logic [wwmc_pkg::BYTE_W-1:0] byte_q,
    output logic                      valid_q,
    output logic                      eq,
    output logic                      letter
);
    import wwmc_pkg::*;

    logic [BYTE_W-1:0] byte_reg;
    logic              valid_reg;
    logic              valid_next;

    always_comb
    begin
        valid_next = valid_reg;
        if (ctl.shift)
            valid_next = valid_in;
        else if (ctl.flush)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (ctl.shift)
                byte_reg <= byte_in;
        end
    end

    assign byte_q  = byte_reg;
    assign valid_q = valid_reg;
    assign eq      = (byte_reg == target);
    assign letter  = is_letter(byte_reg);

endmodule

[design/whole_word_match_counter.sv]
// Channel   Handshake           Payload
// config    psel/penable/pready paddr, pwdata, prdata (64-bit, regs at 0x0/0x8/0x10)
// text in   in_valid/in_ready   text_byte, end_of_text
// count out out_valid/out_ready word_count
//
// One text byte per cycle while in_ready is high; the window is a row of
// MAX_WORD_LEN+1 shift cells, each comparing its byte against the aligned word byte.
// end_of_text sets fin_reg; when the output is free, word_count and out_valid load.
// in_ready drops only while a finished count waits behind a stalled output.
// Reset clears window valid bits and the count; registers go to word_length 1.
module whole_word_match_counter #(
    parameter int MAX_WORD_LEN = wwmc_pkg::DEF_MAX_WORD_LEN,
    parameter int COUNT_BITS   = wwmc_pkg::DEF_COUNT_BITS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [wwmc_pkg::ADDR_W-1:0] paddr,
    input  logic [wwmc_pkg::DATA_W-1:0] pwdata,
    output logic [wwmc_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [wwmc_pkg::BYTE_W-1:0] text_byte,
    input  logic                        end_of_text,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [wwmc_pkg::OUT_W-1:0]  word_count
);
    import wwmc_pkg::*;

    localparam int WIN   = MAX_WORD_LEN + 1;
    localparam int LEN_W = $clog2(MAX_WORD_LEN + 1);

    logic [DATA_W-1:0]    word_first_reg;
    logic [REST_W-1:0]    word_rest_reg;
    logic [LEN_REG_W-1:0] word_len_reg;
    logic [1:0]           reg_idx;
    logic                 cfg_wr;

    logic [LEN_W-1:0]  eff_len;
    logic [BYTE_W-1:0] wb       [MAX_WORD_LEN];
    logic [BYTE_W-1:0] target   [WIN];
    logic [BYTE_W-1:0] chain_in [WIN];
    logic [BYTE_W-1:0] cell_byte[WIN];
    logic [WIN-1:0]    chain_valid_in;
    logic [WIN-1:0]    cell_valid;
    logic [WIN-1:0]    cell_eq;
    logic [WIN-1:0]    cell_letter;
    cell_ctl_t         cell_ctl;

    logic [BYTE_W-1:0]     in_byte_f;
    logic                  all_ok, have_word, have_prev, prev_letter, win_match;
    logic                  out_free, accept, fin_go, bump;
    logic                  fin_reg, fin_next;
    logic                  out_valid_reg, out_valid_next;
    logic [COUNT_BITS-1:0] total_reg, total_next, count_inc, fin_total;
    logic [OUT_W-1:0]      word_count_reg, word_count_next;

    // configuration port
    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:3];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_first_reg <= '0;
            word_rest_reg  <= '0;
            word_len_reg   <= LEN_REG_W'(1);
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                REG_WORD_FIRST: word_first_reg <= pwdata;
                REG_WORD_REST:  word_rest_reg  <= pwdata[REST_W-1:0];
                REG_WORD_LEN:   word_len_reg   <= pwdata[LEN_REG_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_WORD_FIRST: prdata = word_first_reg;
            REG_WORD_REST:  prdata = DATA_W'(word_rest_reg);
            REG_WORD_LEN:   prdata = DATA_W'(word_len_reg);
            default:        prdata = '0;
        endcase
    end

    // length clamped to 1..MAX_WORD_LEN
    always_comb
    begin
        if (word_len_reg == '0)
            eff_len = LEN_W'(1);
        else if (32'(word_len_reg) > MAX_WORD_LEN)
            eff_len = LEN_W'(MAX_WORD_LEN);
        else
            eff_len = LEN_W'(word_len_reg);
    end

    for (genvar j = 0; j < MAX_WORD_LEN; j++)
    begin : g_wb
        if (j < WORD_FIRST_BYTES)
        begin : g_first
            assign wb[j] = fold(word_first_reg[BYTE_W*j +: BYTE_W]);
        end
        else if (j < WORD_BYTES)
        begin : g_rest
            assign wb[j] = fold(word_rest_reg[BYTE_W*(j-WORD_FIRST_BYTES) +: BYTE_W]);
        end
        else
        begin : g_zero
            assign wb[j] = '0;
        end
    end

    // cell k holds the word byte len-1-k; its newest byte is the word's last
    always_comb
    begin
        for (int k = 0; k < WIN; k++)
        begin
            target[k] = '0;
            for (int j = 0; j < MAX_WORD_LEN; j++)
                if (32'(eff_len) == 32'(j + k + 1))
                    target[k] = wb[j];
        end
    end

    // shift chain
    assign in_byte_f    = fold(text_byte);
    assign cell_ctl.shift = accept;
    assign cell_ctl.flush = fin_go;

    for (genvar k = 0; k < WIN; k++)
    begin : g_cell
        if (k == 0)
        begin : g_head
            assign chain_in[k]       = in_byte_f;
            assign chain_valid_in[k] = 1'b1;
        end
        else
        begin : g_body
            // a pending finish means the new byte starts a fresh text
            assign chain_in[k]       = cell_byte[k-1];
            assign chain_valid_in[k] = cell_valid[k-1] && !fin_reg;
        end

        wwmc_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (cell_ctl),
            .byte_in  (chain_in[k]),
            .valid_in (chain_valid_in[k]),
            .target   (target[k]),
            .byte_q   (cell_byte[k]),
            .valid_q  (cell_valid[k]),
            .eq       (cell_eq[k]),
            .letter   (cell_letter[k])
        );
    end

    // match of the word ending at the newest stored byte
    always_comb
    begin
        all_ok      = 1'b1;
        have_word   = 1'b0;
        have_prev   = 1'b0;
        prev_letter = 1'b0;
        for (int k = 0; k < WIN; k++)
        begin
            if (32'(eff_len) > 32'(k) && !cell_eq[k])
                all_ok = 1'b0;
            if (32'(eff_len) == 32'(k + 1))
                have_word = cell_valid[k];
            if (32'(eff_len) == 32'(k))
            begin
                have_prev   = cell_valid[k];
                prev_letter = cell_letter[k];
            end
        end
    end

    assign win_match = all_ok && have_word && !(have_prev && prev_letter);

    // control
    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = !fin_reg || out_free;
    assign accept   = in_valid && in_ready;
    assign fin_go   = fin_reg && out_free;
    assign bump     = !fin_reg && win_match && !is_letter(in_byte_f);

    assign count_inc = (&total_reg) ? total_reg : total_reg + COUNT_BITS'(1);
    assign fin_total = win_match ? count_inc : total_reg;

    always_comb
    begin
        fin_next        = fin_reg;
        total_next      = total_reg;
        out_valid_next  = out_valid_reg;
        word_count_next = word_count_reg;

        if (accept)
        begin
            fin_next   = end_of_text;
            total_next = fin_reg ? '0 : (bump ? count_inc : total_reg);
        end
        else if (fin_go)
        begin
            fin_next   = 1'b0;
            total_next = '0;
        end

        if (fin_go)
        begin
            out_valid_next  = 1'b1;
            word_count_next = OUT_W'(fin_total);
        end
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_reg       <= 1'b0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fin_reg       <= fin_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_count_reg <= word_count_next;
    end

    assign out_valid  = out_valid_reg;
    assign word_count = word_count_reg;

endmodule

[design/wwmc_checker.sv]
`include "whole_word_match_counter_defines.svh"

module wwmc_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       pready,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       end_of_text,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [wwmc_pkg::OUT_W-1:0] word_count
);
    import wwmc_pkg::*;

    logic last_accept;

    assign last_accept = in_valid && in_ready && end_of_text;

    `WWMC_ASSERT_IMP(a_count_follows, clk, rst_n, last_accept, ##2 out_valid, "no count after end of text")
    `WWMC_ASSERT_IMP(a_stall_cause, clk, rst_n, !in_ready, out_valid && !out_ready, "input stalled without output backpressure")
    `WWMC_ASSERT_IMP(a_pready, clk, rst_n, 1'b1, pready, "pready low")
    `WWMC_ASSERT_NXT(a_count_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(word_count), "stalled count changed")

endmodule

bind whole_word_match_counter wwmc_checker u_wwmc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .pready      (pready),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .end_of_text (end_of_text),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .word_count  (word_count)
);

[verif/whole_word_match_counter_tb.sv]
module whole_word_match_counter_tb;
    import wwmc_pkg::*;

    localparam int WIN_LEN      = DEF_MAX_WORD_LEN + 1;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_ITEMS = 1050;
    localparam int HOLD_CYCLES  = 250;
    localparam int BURST_TEXTS  = 40;
    localparam logic [OUT_W-1:0] COUNT_CEIL = '1;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef enum logic {ROW_WRITE, ROW_TEXT} row_kind_t;

    typedef struct {
        row_kind_t         kind;
        logic [1:0]        reg_idx;
        logic [DATA_W-1:0] value;
        byte_t             text;
        logic              eot;
        logic              typed;
        logic [OUT_W-1:0]  count;
    } stim_row_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              in_valid = 1'b0;
    logic              in_ready;
    byte_t             text_byte = '0;
    logic              end_of_text = 1'b0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [OUT_W-1:0]  word_count;

    // shadow copy of the configuration
    logic [DATA_W-1:0]    word_first = '0;
    logic [REST_W-1:0]    word_rest = '0;
    logic [LEN_REG_W-1:0] word_len_reg = 4'd1;

    // folded text window, newest byte at index 0
    byte_t            window [WIN_LEN] = '{default: '0};
    int unsigned      bytes_taken = 0;
    logic [OUT_W-1:0] running_count = '0;

    logic [OUT_W-1:0] counts_due [$];
    logic [OUT_W-1:0] count_want;
    stim_row_t        opening_rows [$];
    int unsigned      mismatches = 0;
    int unsigned      hold_request = 0;
    int unsigned      items_sent = 0;

    whole_word_match_counter uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .text_byte   (text_byte),
        .end_of_text (end_of_text),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .word_count  (word_count)
    );

    always #5 clk = ~clk;

    initial
    begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic byte_t fold_case(byte_t b);
        return (b >= FOLD_LO && b <= FOLD_HI) ? b + CASE_GAP : b;
    endfunction

    function automatic bit alpha(byte_t b);
        return b >= LETTER_LO && b <= LETTER_HI;
    endfunction

    function automatic int unsigned used_len();
        int unsigned n;
        n = 32'(word_len_reg);
        if (n < 1)
            n = 1;
        if (n > DEF_MAX_WORD_LEN)
            n = DEF_MAX_WORD_LEN;
        return n;
    endfunction

    function automatic byte_t raw_word_byte(int unsigned k);
        if (k < WORD_FIRST_BYTES)
            return word_first[8*k +: 8];
        if (k < WORD_BYTES)
            return word_rest[8*(k-WORD_FIRST_BYTES) +: 8];
        return '0;
    endfunction

    // word sits in window[n-1..0]; window[n] is the byte before it, if any
    function automatic bit word_ends_here(int unsigned n);
        if (bytes_taken < n)
            return 1'b0;
        for (int unsigned k = 0; k < n; k++)
            if (window[n-1-k] != fold_case(raw_word_byte(k)))
                return 1'b0;
        return !(bytes_taken > n && alpha(window[n]));
    endfunction

    function automatic void bump_count();
        if (running_count != COUNT_CEIL)
            running_count++;
    endfunction

    function automatic bit take_text_byte(byte_t raw, logic eot, output logic [OUT_W-1:0] total);
        byte_t       b;
        int unsigned n;
        b = fold_case(raw);
        n = used_len();
        total = '0;
        // match ending on the previous byte, closed by this one
        if (word_ends_here(n) && !alpha(b))
            bump_count();
        for (int i = WIN_LEN - 1; i > 0; i--)
            window[i] = window[i-1];
        window[0] = b;
        if (bytes_taken < WIN_LEN)
            bytes_taken++;
        if (!eot)
            return 1'b0;
        if (word_ends_here(n))
            bump_count();
        total = running_count;
        window = '{default: '0};
        bytes_taken = 0;
        running_count = '0;
        return 1'b1;
    endfunction

    function automatic void report_miss(string what, logic [DATA_W-1:0] want,
                                        logic [DATA_W-1:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %0d at %0t: %s expected %0h got %0h",
                     mismatches, $realtime, what, want, got);
    endfunction

    function automatic byte_t any_non_letter();
        byte_t b;
        if ($urandom_range(1))
            return 8'h20;
        do
            b = byte_t'($urandom_range(255));
        while (alpha(fold_case(b)));
        return b;
    endfunction

    function automatic int unsigned next_gap(bit steady);
        int unsigned pick;
        if (steady)
            return 0;
        pick = $urandom_range(99);
        if (pick < 70)
            return 0;
        if (pick < 95)
            return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    function automatic void add_write(logic [1:0] idx, logic [DATA_W-1:0] value);
        stim_row_t r;
        r = '{kind: ROW_WRITE, reg_idx: idx, value: value, text: '0, eot: 1'b0,
              typed: 1'b0, count: '0};
        opening_rows.push_back(r);
    endfunction

    function automatic void add_text(byte_t b, logic eot, logic typed, logic [OUT_W-1:0] count);
        stim_row_t r;
        r = '{kind: ROW_TEXT, reg_idx: '0, value: '0, text: b, eot: eot,
              typed: typed, count: count};
        opening_rows.push_back(r);
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (counts_due.size() == 0)
                report_miss("word_count with no request pending", '0, DATA_W'(word_count));
            else
            begin
                count_want = counts_due.pop_front();
                if (word_count !== count_want)
                    report_miss("word_count", DATA_W'(count_want), DATA_W'(word_count));
            end
        end
    end

    // receiver: steady stretches, short and long stalls, and requested hold-offs
    initial
    begin
        int unsigned stall_left;
        int unsigned steady_left;
        bit          steady;
        stall_left = 0;
        steady_left = 0;
        steady = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request != 0)
            begin
                stall_left = hold_request;
                hold_request = 0;
            end
            if (steady_left == 0)
            begin
                steady = ($urandom_range(3) == 0);
                steady_left = $urandom_range(300, 50);
            end
            else
                steady_left--;
            if (stall_left != 0)
                stall_left--;
            else if (!steady)
                stall_left = next_gap(1'b0);
            out_ready <= (stall_left == 0);
        end
    end

    task automatic send_text(byte_t raw, logic eot, int unsigned gap, logic typed,
                             logic [OUT_W-1:0] typed_count);
        logic [OUT_W-1:0] total;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        text_byte <= raw;
        end_of_text <= eot;
        do
            @(posedge clk);
        while (!in_ready);
        items_sent++;
        if (take_text_byte(raw, eot, total))
            counts_due.push_back(typed ? typed_count : total);
    endtask

    // stop sending and let every pending count come out
    task automatic settle();
        in_valid <= 1'b0;
        while (counts_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [DATA_W-1:0] value);
        logic [DATA_W-1:0] mask;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            REG_WORD_FIRST:
            begin
                word_first = value;
                mask = '1;
            end
            REG_WORD_REST:
            begin
                word_rest = value[REST_W-1:0];
                mask = {{(DATA_W-REST_W){1'b0}}, {REST_W{1'b1}}};
            end
            REG_WORD_LEN:
            begin
                word_len_reg = value[LEN_REG_W-1:0];
                mask = {{(DATA_W-LEN_REG_W){1'b0}}, {LEN_REG_W{1'b1}}};
            end
            default:
                mask = '0;
        endcase
        // read back
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if ((prdata & mask) !== (value & mask))
            report_miss("register read-back", value & mask, prdata & mask);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic pick_word();
        logic [DATA_W-1:0]    first;
        logic [REST_W-1:0]    rest;
        logic [LEN_REG_W-1:0] len;
        int unsigned          style;
        byte_t                b;
        style = $urandom_range(11);
        first = '0;
        rest = '0;
        for (int k = 0; k < WORD_BYTES; k++)
        begin
            if (style < 4)
                b = LETTER_LO + byte_t'($urandom_range(3));
            else if (style < 8)
                b = LETTER_LO + byte_t'($urandom_range(25));
            else if (style < 10)
                b = $urandom_range(1) ? LETTER_LO + byte_t'($urandom_range(25))
                                      : any_non_letter();
            else
                b = byte_t'($urandom_range(255));
            if (alpha(b) && $urandom_range(1))
                b = b - CASE_GAP;
            if (k < WORD_FIRST_BYTES)
                first[8*k +: 8] = b;
            else
                rest[8*(k-WORD_FIRST_BYTES) +: 8] = b;
        end
        len = LEN_REG_W'($urandom_range(1) ? $urandom_range(3, 1)
                                           : $urandom_range(DEF_MAX_WORD_LEN, 1));
        if ($urandom_range(15) == 0)
        begin
            first = $urandom_range(1) ? '1 : '0;
            rest = first[REST_W-1:0];
        end
        if ($urandom_range(9) == 0)
            len = $urandom_range(1) ? '0
                                    : LEN_REG_W'($urandom_range(15, DEF_MAX_WORD_LEN + 1));
        if ($urandom_range(3) != 0)
            write_reg(REG_WORD_FIRST, first);
        if ($urandom_range(3) != 0)
            write_reg(REG_WORD_REST, {{(DATA_W-REST_W){1'b0}}, rest});
        if ($urandom_range(3) != 0)
            write_reg(REG_WORD_LEN, {{(DATA_W-LEN_REG_W){1'b0}}, len});
    endtask

    // text built from copies of the word in mixed case, fragments, letters and separators
    task automatic send_phrase(bit finish, bit steady);
        byte_t       phrase [$];
        byte_t       b;
        int unsigned tokens;
        int unsigned pick;
        int unsigned upto;
        tokens = $urandom_range(8, 1);
        for (int t = 0; t < tokens; t++)
        begin
            pick = $urandom_range(99);
            if (pick < 55)
            begin
                upto = (pick < 40) ? used_len() : $urandom_range(used_len(), 1);
                for (int k = 0; k < upto; k++)
                begin
                    b = fold_case(raw_word_byte(k));
                    if (alpha(b) && $urandom_range(1))
                        b = b - CASE_GAP;
                    phrase.push_back(b);
                end
            end
            else if (pick < 80)
                phrase.push_back(any_non_letter());
            else if (pick < 92)
            begin
                b = LETTER_LO + byte_t'($urandom_range(3));
                phrase.push_back($urandom_range(1) ? b - CASE_GAP : b);
            end
            else
                phrase.push_back(byte_t'($urandom_range(255)));
        end
        foreach (phrase[i])
            send_text(phrase[i], finish && (i == phrase.size() - 1), next_gap(steady), 1'b0, '0);
    endtask

    initial
    begin
        int unsigned phase;
        int unsigned texts;
        bit          steady;

        // after reset the word is one zero byte
        add_text(8'h00, 1'b1, 1'b1, 32'd1);
        add_text(8'hFF, 1'b1, 1'b1, 32'd0);
        // zero length acts as one; both sides fold to lower case
        add_write(REG_WORD_LEN, 64'd0);
        add_write(REG_WORD_FIRST, 64'h5A);
        add_text(8'h7A, 1'b1, 1'b1, 32'd1);
        add_text(8'h5A, 1'b0, 1'b0, '0);
        add_text(8'h7B, 1'b0, 1'b0, '0);
        add_text(8'h5A, 1'b1, 1'b1, 32'd2);
        add_text(8'h5A, 1'b0, 1'b0, '0);
        add_text(8'h61, 1'b1, 1'b1, 32'd0);
        // neighbors just outside the letter ranges
        add_text(8'h60, 1'b0, 1'b0, '0);
        add_text(8'h5A, 1'b0, 1'b0, '0);
        add_text(8'h40, 1'b0, 1'b0, '0);
        add_text(8'h7A, 1'b0, 1'b0, '0);
        add_text(8'h5B, 1'b1, 1'b1, 32'd2);
        // longest word of non-letters, length register above the maximum
        add_write(REG_WORD_FIRST, '1);
        add_write(REG_WORD_REST, 64'hFFFF);
        add_write(REG_WORD_LEN, 64'd15);
        for (int i = 0; i < DEF_MAX_WORD_LEN; i++)
            add_text(8'hFF, i == DEF_MAX_WORD_LEN - 1, i == DEF_MAX_WORD_LEN - 1, 32'd1);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (opening_rows[i])
        begin
            if (opening_rows[i].kind == ROW_WRITE)
            begin
                settle();
                write_reg(opening_rows[i].reg_idx, opening_rows[i].value);
            end
            else
                send_text(opening_rows[i].text, opening_rows[i].eot, next_gap(1'b0),
                          opening_rows[i].typed, opening_rows[i].count);
        end

        phase = 0;
        while (items_sent < opening_rows.size() + RANDOM_ITEMS)
        begin
            settle();
            pick_word();
            if (phase == 2 || phase == 50)
            begin
                // output held off while short texts keep coming
                hold_request = HOLD_CYCLES;
                for (int n = 0; n < BURST_TEXTS; n++)
                begin
                    if ($urandom_range(1))
                        send_text(byte_t'($urandom_range(255)), 1'b0, 0, 1'b0, '0);
                    send_text(fold_case(raw_word_byte(0)), 1'b1, 0, 1'b0, '0);
                end
            end
            steady = ($urandom_range(3) == 0);
            texts = $urandom_range(4, 1);
            for (int t = 0; t < texts; t++)
                // an unfinished last text carries over into the next word setting
                send_phrase(t != texts - 1 || $urandom_range(7) != 0, steady);
            phase++;
        end

        settle();
        if (mismatches == 0 && counts_due.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
